// ----- rtl/core/fais_pkg.sv -----
// ----------------------------------------------------------------------------
// fais_pkg: shared types for the fixed array core
// Operation and status codes, element type, the cell control group and FSM states.
// ----------------------------------------------------------------------------
package fais_pkg;

    localparam int unsigned POS_W  = 4;
    localparam int unsigned ELEM_W = 32;

    typedef logic signed [ELEM_W-1:0] elem_t;

    typedef enum logic [2:0] {
        OP_INSERT   = 3'd0,
        OP_DELETE   = 3'd1,
        OP_SEARCH   = 3'd2,
        OP_REVERSE  = 3'd3,
        OP_READ_ALL = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_BAD_POS   = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE,
        CELL_MIRROR,
        CELL_ROTATE
    } cell_op_t;

    typedef enum logic {
        FSM_IDLE,
        FSM_READ
    } fsm_t;

    typedef struct packed {
        cell_op_t           op;
        logic [POS_W-1:0]   position;
        elem_t              value;
    } cell_ctrl_t;

endpackage

// ----- rtl/core/fais_cell.sv -----
// ----------------------------------------------------------------------------
// fais_cell: one slot of the element row
// Holds one element, compares it with the broadcast value and takes its
// next value from itself, a neighbor, its mirror slot or the broadcast.
// ----------------------------------------------------------------------------
module fais_cell
    import fais_pkg::*;
#(
    parameter int unsigned IDX = 0
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  cell_ctrl_t ctrl,
    input  elem_t      left_in,
    input  elem_t      right_in,
    input  elem_t      mirror_in,
    input  logic       seen_in,
    output elem_t      elem_out,
    output logic       seen_out,
    output logic       first_out
);

    localparam int unsigned SW = $clog2(IDX + 2);
    localparam int unsigned CW = (SW > POS_W) ? SW : POS_W;
    localparam logic [CW-1:0] SLOT = CW'(IDX + 1);

    elem_t          elem_reg;
    elem_t          elem_next;
    logic           match;
    logic [CW-1:0]  pos_ext;

    assign match     = (elem_reg == ctrl.value);
    assign seen_out  = seen_in | match;
    assign first_out = match & ~seen_in;
    assign elem_out  = elem_reg;
    assign pos_ext   = CW'(ctrl.position);

    always_comb begin
        elem_next = elem_reg;
        unique case (ctrl.op)
            CELL_HOLD: begin
                elem_next = elem_reg;
            end
            CELL_INSERT: begin
                // slots above the target take the lower neighbor
                if (SLOT == pos_ext) begin
                    elem_next = ctrl.value;
                end else if (SLOT > pos_ext) begin
                    elem_next = left_in;
                end
            end
            CELL_DELETE: begin
                // match at or below this slot: pull from above
                if (seen_out) begin
                    elem_next = right_in;
                end
            end
            CELL_MIRROR: begin
                elem_next = mirror_in;
            end
            CELL_ROTATE: begin
                elem_next = right_in;
            end
            default: begin
                elem_next = elem_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            elem_reg <= '0;
        end else begin
            elem_reg <= elem_next;
        end
    end

endmodule

// ----- rtl/core/fixed_array_insert_delete_search_core.sv -----
// ----------------------------------------------------------------------------
// fixed_array_insert_delete_search_core: row of DEPTH signed elements
// Insert, delete, search and reverse work in parallel across a chain of cells;
// read-out rotates the chain one slot per beat.
// Result beats are registered.
// Throughput: insert/delete/search/reverse one item per cycle while the
// output drains; read-out gives one beat per chain rotation and takes no new item.
// Reset: all elements zero at once, output empty, no clearing pass.
// ----------------------------------------------------------------------------
module fixed_array_insert_delete_search_core
    import fais_pkg::*;
#(
    parameter int unsigned DEPTH = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // operation[2:0], position[6:3], value[38:7]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // status[1:0], found_position[5:2], element[37:6]
    output logic        m_tlast
);

    localparam int unsigned CNT_W = $clog2(DEPTH);
    localparam int unsigned PW    = $clog2(DEPTH + 1);
    localparam int unsigned PCW   = (PW > POS_W) ? PW : POS_W;

    op_t                in_op;
    logic [POS_W-1:0]   in_pos;
    elem_t              in_value;

    cell_ctrl_t         ctrl;
    elem_t              elem_w  [DEPTH];
    logic [DEPTH:0]     seen_w;
    logic [DEPTH-1:0]   first_w;
    elem_t              top_right;

    fsm_t               fsm_reg,    fsm_next;
    logic [CNT_W-1:0]   cnt_reg,    cnt_next;
    logic               m_valid_reg, m_valid_next;
    status_t            status_reg, status_next;
    logic [POS_W-1:0]   fpos_reg,   fpos_next;
    elem_t              element_reg, element_next;
    logic               last_reg,   last_next;

    logic               out_free;
    logic               accept;
    logic               found;
    logic [POS_W-1:0]   found_pos;
    logic [PCW-1:0]     pos_ext;
    logic               pos_ok;

    assign in_op    = op_t'(s_tdata[2:0]);
    assign in_pos   = s_tdata[6:3];
    assign in_value = s_tdata[38:7];

    // ---------------- cell chain ----------------
    assign seen_w[0]  = 1'b0;
    assign top_right  = (ctrl.op == CELL_ROTATE) ? elem_w[0] : '0;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        elem_t left_i;
        elem_t right_i;

        if (i == 0) begin : g_lo
            assign left_i = '0;
        end else begin : g_lo
            assign left_i = elem_w[i-1];
        end

        if (i == DEPTH - 1) begin : g_hi
            assign right_i = top_right;
        end else begin : g_hi
            assign right_i = elem_w[i+1];
        end

        fais_cell #(
            .IDX(i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .left_in   (left_i),
            .right_in  (right_i),
            .mirror_in (elem_w[DEPTH-1-i]),
            .seen_in   (seen_w[i]),
            .elem_out  (elem_w[i]),
            .seen_out  (seen_w[i+1]),
            .first_out (first_w[i])
        );
    end

    assign found = seen_w[DEPTH];

    // first_w is at most one-hot, so an OR of slot numbers encodes it
    always_comb begin
        found_pos = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (first_w[i]) begin
                found_pos = found_pos | POS_W'(i + 1);
            end
        end
    end

    assign pos_ext = PCW'(in_pos);
    assign pos_ok  = (pos_ext != '0) && (pos_ext <= PCW'(DEPTH));

    // ---------------- control ----------------
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (fsm_reg == FSM_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        fsm_next      = fsm_reg;
        cnt_next      = cnt_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        status_next   = status_reg;
        fpos_next     = fpos_reg;
        element_next  = element_reg;
        last_next     = last_reg;
        ctrl.op       = CELL_HOLD;
        ctrl.position = in_pos;
        ctrl.value    = in_value;

        unique case (fsm_reg)
            FSM_IDLE: begin
                if (accept) begin
                    status_next  = STAT_OK;
                    fpos_next    = '0;
                    element_next = '0;
                    last_next    = 1'b1;
                    unique case (in_op)
                        OP_INSERT: begin
                            m_valid_next = 1'b1;
                            if (pos_ok) begin
                                ctrl.op = CELL_INSERT;
                            end else begin
                                status_next = STAT_BAD_POS;
                            end
                        end
                        OP_DELETE: begin
                            m_valid_next = 1'b1;
                            if (found) begin
                                ctrl.op   = CELL_DELETE;
                                fpos_next = found_pos;
                            end else begin
                                status_next = STAT_NOT_FOUND;
                            end
                        end
                        OP_SEARCH: begin
                            m_valid_next = 1'b1;
                            if (found) begin
                                fpos_next = found_pos;
                            end else begin
                                status_next = STAT_NOT_FOUND;
                            end
                        end
                        OP_REVERSE: begin
                            m_valid_next = 1'b1;
                            ctrl.op      = CELL_MIRROR;
                        end
                        OP_READ_ALL: begin
                            fsm_next = FSM_READ;
                            cnt_next = '0;
                        end
                        default: begin
                            // unused codes: dropped, no beat
                        end
                    endcase
                end
            end
            FSM_READ: begin
                // slot 1 sits at the chain head; rotating DEPTH times restores order
                if (out_free) begin
                    ctrl.op      = CELL_ROTATE;
                    m_valid_next = 1'b1;
                    status_next  = STAT_OK;
                    fpos_next    = '0;
                    element_next = elem_w[0];
                    last_next    = (cnt_reg == CNT_W'(DEPTH - 1));
                    if (cnt_reg == CNT_W'(DEPTH - 1)) begin
                        cnt_next = '0;
                        fsm_next = FSM_IDLE;
                    end else begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            default: begin
                fsm_next = FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fsm_reg     <= FSM_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            fsm_reg     <= fsm_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg  <= status_next;
        fpos_reg    <= fpos_next;
        element_reg <= element_next;
        last_reg    <= last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, element_reg, fpos_reg, status_reg};
    assign m_tlast  = last_reg;

    // ---------------- assertions ----------------
    a_first_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(first_w))
        else $error("more than one first-match cell");

    a_found_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        (|first_w) == found)
        else $error("match chain and first-match flags disagree");

    a_read_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && in_op == OP_READ_ALL) |=> (fsm_reg == FSM_READ && cnt_reg == '0))
        else $error("read-out did not start");

    a_idle_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        (fsm_reg == FSM_IDLE) |-> (cnt_reg == '0))
        else $error("beat counter not cleared in idle");

endmodule
